// ===== src/mwrm_pkg.sv =====
// mwrm_pkg: shared types and constants for the memory watch region matcher
// holds opcodes, result kinds, region entry layout, controller states and the
// command/status structs between controller and datapath; depends on nothing
`default_nettype none

package mwrm_pkg;

  localparam int ADDR_W  = 64;
  localparam int SIZE_W  = 13;
  localparam int FLAGS_W = 6;
  localparam int INDEX_W = 4;

  // region flag bit positions
  localparam int FLAG_READ     = 0;
  localparam int FLAG_WRITE    = 1;
  localparam int FLAG_BEFORE   = 2;
  localparam int FLAG_AFTER    = 3;
  localparam int FLAG_VIRTUAL  = 4;
  localparam int FLAG_PHYSICAL = 5;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CHECK = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_ADDED = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_HIT   = 2'd2
  } result_kind_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  start;
    logic [ADDR_W-1:0]  stop;
    logic               enabled;
    logic [FLAGS_W-1:0] flags;
  } region_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic capture;
    logic add_go;
    logic scan_start;
    logic scan_step;
    logic flush_go;
  } dp_cmd_t;

  typedef struct packed {
    logic is_check;
    logic count_zero;
    logic hit;
    logic pend_valid;
    logic at_end;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/mwrm_ctrl.sv =====
// mwrm_ctrl: controller state machine for the watch region matcher
// sequences add and scan of one word at a time; uses mwrm_pkg
`default_nettype none

module mwrm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire mwrm_pkg::dp_status_t status,
  output mwrm_pkg::dp_cmd_t         cmd
);

  mwrm_pkg::state_t state_r;
  mwrm_pkg::state_t state_nxt;
  logic             step_ok;

  // a hit with a held hit needs room in the output register
  assign step_ok = !status.hit || !status.pend_valid || status.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mwrm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mwrm_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (!status.is_check) begin
            state_nxt = mwrm_pkg::ST_ADD;
          end else if (!status.count_zero) begin
            state_nxt = mwrm_pkg::ST_READ;
          end
        end
      end
      mwrm_pkg::ST_ADD: begin
        if (status.out_free) begin
          state_nxt = mwrm_pkg::ST_IDLE;
        end
      end
      mwrm_pkg::ST_READ: begin
        state_nxt = mwrm_pkg::ST_EVAL;
      end
      mwrm_pkg::ST_EVAL: begin
        if (step_ok && status.at_end) begin
          state_nxt = mwrm_pkg::ST_FLUSH;
        end
      end
      mwrm_pkg::ST_FLUSH: begin
        if (!status.pend_valid || status.out_free) begin
          state_nxt = mwrm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mwrm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != mwrm_pkg::ST_IDLE);
    case (state_r)
      mwrm_pkg::ST_IDLE: begin
        cmd.capture = in_valid;
      end
      mwrm_pkg::ST_ADD: begin
        cmd.add_go = status.out_free;
      end
      mwrm_pkg::ST_READ: begin
        cmd.scan_start = 1'b1;
      end
      mwrm_pkg::ST_EVAL: begin
        cmd.scan_step = step_ok;
      end
      mwrm_pkg::ST_FLUSH: begin
        cmd.flush_go = status.pend_valid && status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/mwrm_datapath.sv =====
// mwrm_datapath: region memory, access latch, range/kind test and output register
// driven by mwrm_ctrl through dp_cmd_t; uses mwrm_pkg
`default_nettype none

module mwrm_datapath #(
  parameter int MAX_REGIONS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire mwrm_pkg::dp_cmd_t                   cmd,
  output mwrm_pkg::dp_status_t                     status,
  input  wire logic                                in_opcode,
  input  wire logic [mwrm_pkg::ADDR_W-1:0]         in_access_pc,
  input  wire logic [mwrm_pkg::ADDR_W-1:0]         in_access_addr,
  input  wire logic [mwrm_pkg::SIZE_W-1:0]         in_access_size,
  input  wire logic                                in_access_write,
  input  wire logic                                in_access_before,
  input  wire logic                                in_access_physical,
  input  wire logic [mwrm_pkg::ADDR_W-1:0]         in_region_start,
  input  wire logic [mwrm_pkg::ADDR_W-1:0]         in_region_stop,
  input  wire logic [mwrm_pkg::FLAGS_W-1:0]        in_region_flags,
  input  wire logic                                in_region_enabled,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               out_result_kind,
  output logic [mwrm_pkg::INDEX_W-1:0]             out_region_index,
  output logic [mwrm_pkg::ADDR_W-1:0]              out_hit_pc,
  output logic [mwrm_pkg::ADDR_W-1:0]              out_hit_addr,
  output logic [mwrm_pkg::SIZE_W-1:0]              out_hit_size,
  output logic                                     out_hit_write,
  output logic                                     out_hit_before,
  output logic                                     out_hit_physical,
  output logic                                     out_last
);

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  mwrm_pkg::region_t mem [MAX_REGIONS];
  mwrm_pkg::region_t rd_data_r;
  mwrm_pkg::region_t wr_data;
  logic              mem_we;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;

  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  idx_r;
  logic              full_r;
  logic              full;
  logic              pend_valid_r;
  logic [IDX_W-1:0]  pend_idx_r;

  logic [mwrm_pkg::ADDR_W-1:0] acc_pc_r;
  logic [mwrm_pkg::ADDR_W-1:0] acc_addr_r;
  logic [mwrm_pkg::ADDR_W-1:0] acc_end_r;
  logic [mwrm_pkg::SIZE_W-1:0] acc_size_r;
  logic                        acc_write_r;
  logic                        acc_before_r;
  logic                        acc_physical_r;

  logic range_ok;
  logic dir_ok;
  logic when_ok;
  logic space_ok;
  logic hit;

  logic                          load_add;
  logic                          load_emit;
  logic                          load_any;
  logic                          out_free;
  logic [IDX_W-1:0]              sel_idx;
  logic [IDX_W+mwrm_pkg::INDEX_W-1:0] sel_idx_ext;

  logic                          out_valid_r;
  mwrm_pkg::result_kind_t        out_kind_r;
  logic [mwrm_pkg::INDEX_W-1:0]  out_index_r;
  logic [mwrm_pkg::ADDR_W-1:0]   out_pc_r;
  logic [mwrm_pkg::ADDR_W-1:0]   out_addr_r;
  logic [mwrm_pkg::SIZE_W-1:0]   out_size_r;
  logic                          out_write_r;
  logic                          out_before_r;
  logic                          out_physical_r;
  logic                          out_last_r;

  assign full = (count_r == CNT_W'(MAX_REGIONS));

  // region memory: append at count, read one entry per scan step
  assign wr_data.start   = in_region_start;
  assign wr_data.stop    = in_region_stop;
  assign wr_data.enabled = in_region_enabled;
  assign wr_data.flags   = in_region_flags;
  assign mem_we  = cmd.capture && (in_opcode == mwrm_pkg::OP_ADD) && !full;
  assign rd_en   = cmd.scan_start || cmd.scan_step;
  assign rd_addr = cmd.scan_start ? '0 : idx_r + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // access latch, end address wraps modulo 2^64
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc_pc_r       <= in_access_pc;
      acc_addr_r     <= in_access_addr;
      acc_end_r      <= in_access_addr + mwrm_pkg::ADDR_W'(in_access_size);
      acc_size_r     <= in_access_size;
      acc_write_r    <= in_access_write;
      acc_before_r   <= in_access_before;
      acc_physical_r <= in_access_physical;
      full_r         <= full;
    end
  end

  always_comb begin
    range_ok = ((acc_addr_r >= rd_data_r.start) && (acc_addr_r < rd_data_r.stop)) ||
               ((acc_end_r > rd_data_r.start) && (acc_end_r <= rd_data_r.stop)) ||
               ((acc_addr_r >= rd_data_r.start) && (acc_end_r <= rd_data_r.stop));
    dir_ok   = acc_write_r ? rd_data_r.flags[mwrm_pkg::FLAG_WRITE]
                           : rd_data_r.flags[mwrm_pkg::FLAG_READ];
    when_ok  = acc_before_r ? rd_data_r.flags[mwrm_pkg::FLAG_BEFORE]
                            : rd_data_r.flags[mwrm_pkg::FLAG_AFTER];
    space_ok = acc_physical_r ? rd_data_r.flags[mwrm_pkg::FLAG_PHYSICAL]
                              : rd_data_r.flags[mwrm_pkg::FLAG_VIRTUAL];
    hit      = rd_data_r.enabled && range_ok && dir_ok && when_ok && space_ok;
  end

  // count, scan index and the held hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      idx_r        <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        if (in_opcode == mwrm_pkg::OP_ADD) begin
          idx_r <= count_r[IDX_W-1:0];
        end
        if (mem_we) begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if (cmd.scan_start) begin
        idx_r        <= '0;
        pend_valid_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        idx_r <= idx_r + IDX_W'(1);
        if (hit) begin
          pend_valid_r <= 1'b1;
        end
      end
      if (cmd.flush_go) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && hit) begin
      pend_idx_r <= idx_r;
    end
  end

  // output register
  assign out_free  = !out_valid_r || !out_stall;
  assign load_add  = cmd.add_go;
  assign load_emit = cmd.scan_step && hit && pend_valid_r;
  assign load_any  = load_add || load_emit || cmd.flush_go;

  assign sel_idx     = load_add ? (full_r ? '0 : idx_r) : pend_idx_r;
  assign sel_idx_ext = {{mwrm_pkg::INDEX_W{1'b0}}, sel_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_any) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_any) begin
      out_index_r <= sel_idx_ext[mwrm_pkg::INDEX_W-1:0];
      out_last_r  <= !load_emit;
      if (load_add) begin
        out_kind_r     <= full_r ? mwrm_pkg::KIND_FULL : mwrm_pkg::KIND_ADDED;
        out_pc_r       <= '0;
        out_addr_r     <= '0;
        out_size_r     <= '0;
        out_write_r    <= 1'b0;
        out_before_r   <= 1'b0;
        out_physical_r <= 1'b0;
      end else begin
        out_kind_r     <= mwrm_pkg::KIND_HIT;
        out_pc_r       <= acc_pc_r;
        out_addr_r     <= acc_addr_r;
        out_size_r     <= acc_size_r;
        out_write_r    <= acc_write_r;
        out_before_r   <= acc_before_r;
        out_physical_r <= acc_physical_r;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_region_index = out_index_r;
  assign out_hit_pc       = out_pc_r;
  assign out_hit_addr     = out_addr_r;
  assign out_hit_size     = out_size_r;
  assign out_hit_write    = out_write_r;
  assign out_hit_before   = out_before_r;
  assign out_hit_physical = out_physical_r;
  assign out_last         = out_last_r;

  assign status.is_check   = (in_opcode == mwrm_pkg::OP_CHECK);
  assign status.count_zero = (count_r == '0);
  assign status.hit        = hit;
  assign status.pend_valid = pend_valid_r;
  assign status.at_end     = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign status.out_free   = out_free;

endmodule

`default_nettype wire

// ===== src/memory_watch_region_matcher_top.sv =====
// memory_watch_region_matcher_top: watchpoint region table and access matcher
// instantiates mwrm_ctrl and mwrm_datapath; uses mwrm_pkg
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall   | add region or check access
//   out_    | output    | out_valid/out_stall | added, table full or hook hit
//
// one word at a time: an add is captured, then loaded into the output register
// when it has room; a check is captured, starts the read, scans the stored regions
// via the single read port, then flushes; a check of an empty table only captures.
// a stalled output holds the scan when a second hit needs the output register.
// synchronous active-low reset empties the table; entries need no clearing.
`default_nettype none

module memory_watch_region_matcher_top #(
  parameter int MAX_REGIONS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_opcode,
  input  wire logic [mwrm_pkg::ADDR_W-1:0]  in_access_pc,
  input  wire logic [mwrm_pkg::ADDR_W-1:0]  in_access_addr,
  input  wire logic [mwrm_pkg::SIZE_W-1:0]  in_access_size,
  input  wire logic                         in_access_write,
  input  wire logic                         in_access_before,
  input  wire logic                         in_access_physical,
  input  wire logic [mwrm_pkg::ADDR_W-1:0]  in_region_start,
  input  wire logic [mwrm_pkg::ADDR_W-1:0]  in_region_stop,
  input  wire logic [mwrm_pkg::FLAGS_W-1:0] in_region_flags,
  input  wire logic                         in_region_enabled,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_result_kind,
  output logic [mwrm_pkg::INDEX_W-1:0]      out_region_index,
  output logic [mwrm_pkg::ADDR_W-1:0]       out_hit_pc,
  output logic [mwrm_pkg::ADDR_W-1:0]       out_hit_addr,
  output logic [mwrm_pkg::SIZE_W-1:0]       out_hit_size,
  output logic                              out_hit_write,
  output logic                              out_hit_before,
  output logic                              out_hit_physical,
  output logic                              out_last
);

  mwrm_pkg::dp_cmd_t    cmd;
  mwrm_pkg::dp_status_t status;

  mwrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mwrm_datapath #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_opcode          (in_opcode),
    .in_access_pc       (in_access_pc),
    .in_access_addr     (in_access_addr),
    .in_access_size     (in_access_size),
    .in_access_write    (in_access_write),
    .in_access_before   (in_access_before),
    .in_access_physical (in_access_physical),
    .in_region_start    (in_region_start),
    .in_region_stop     (in_region_stop),
    .in_region_flags    (in_region_flags),
    .in_region_enabled  (in_region_enabled),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_region_index   (out_region_index),
    .out_hit_pc         (out_hit_pc),
    .out_hit_addr       (out_hit_addr),
    .out_hit_size       (out_hit_size),
    .out_hit_write      (out_hit_write),
    .out_hit_before     (out_hit_before),
    .out_hit_physical   (out_hit_physical),
    .out_last           (out_last)
  );

  // add and table-full words are always the only word of their item
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind != mwrm_pkg::KIND_HIT)) |-> out_last)
    else $error("add or full word without last");

  // a full table reports index zero and no access echo
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == mwrm_pkg::KIND_FULL)) |->
      ((out_region_index == '0) && (out_hit_pc == '0) && (out_hit_addr == '0)))
    else $error("full word carries data");

  // a new word cannot be accepted while a hit is still held
  assert property (@(posedge clk) disable iff (!rst_n)
    (status.pend_valid) |-> in_stall)
    else $error("input accepted with a held hit");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench: self-checking bench for memory_watch_region_matcher_top
// predicts added, table-full and hook-hit words from a local copy of the region table
// depends on mwrm_pkg and the top module only
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_W        = mwrm_pkg::ADDR_W;
  localparam int SIZE_W        = mwrm_pkg::SIZE_W;
  localparam int FLAGS_W       = mwrm_pkg::FLAGS_W;
  localparam int INDEX_W       = mwrm_pkg::INDEX_W;
  localparam int FLAG_READ     = mwrm_pkg::FLAG_READ;
  localparam int FLAG_WRITE    = mwrm_pkg::FLAG_WRITE;
  localparam int FLAG_BEFORE   = mwrm_pkg::FLAG_BEFORE;
  localparam int FLAG_AFTER    = mwrm_pkg::FLAG_AFTER;
  localparam int FLAG_VIRTUAL  = mwrm_pkg::FLAG_VIRTUAL;
  localparam int FLAG_PHYSICAL = mwrm_pkg::FLAG_PHYSICAL;

  localparam int REGION_SLOTS = 16;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;
  localparam logic [FLAGS_W-1:0] KINDS_RBV =
    FLAGS_W'((1 << FLAG_READ) | (1 << FLAG_BEFORE) | (1 << FLAG_VIRTUAL));
  localparam logic [FLAGS_W-1:0] KINDS_WAP =
    FLAGS_W'((1 << FLAG_WRITE) | (1 << FLAG_AFTER) | (1 << FLAG_PHYSICAL));

  typedef struct {
    mwrm_pkg::opcode_t   op;
    logic [ADDR_W-1:0]   pc;
    logic [ADDR_W-1:0]   addr;
    logic [SIZE_W-1:0]   size;
    logic                wr;
    logic                bf;
    logic                ph;
    logic [ADDR_W-1:0]   rstart;
    logic [ADDR_W-1:0]   rstop;
    logic [FLAGS_W-1:0]  rflags;
    logic                ren;
  } watch_word_t;

  typedef struct {
    mwrm_pkg::result_kind_t kind;
    logic [INDEX_W-1:0]  index;
    logic [ADDR_W-1:0]   pc;
    logic [ADDR_W-1:0]   addr;
    logic [SIZE_W-1:0]   size;
    logic                wr;
    logic                bf;
    logic                ph;
    logic                is_last;
  } watch_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_opcode;
  logic [ADDR_W-1:0]   in_access_pc;
  logic [ADDR_W-1:0]   in_access_addr;
  logic [SIZE_W-1:0]   in_access_size;
  logic                in_access_write;
  logic                in_access_before;
  logic                in_access_physical;
  logic [ADDR_W-1:0]   in_region_start;
  logic [ADDR_W-1:0]   in_region_stop;
  logic [FLAGS_W-1:0]  in_region_flags;
  logic                in_region_enabled;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          out_result_kind;
  logic [INDEX_W-1:0]  out_region_index;
  logic [ADDR_W-1:0]   out_hit_pc;
  logic [ADDR_W-1:0]   out_hit_addr;
  logic [SIZE_W-1:0]   out_hit_size;
  logic                out_hit_write;
  logic                out_hit_before;
  logic                out_hit_physical;
  logic                out_last;

  // local copy of the region table
  logic [ADDR_W-1:0]   tbl_start   [REGION_SLOTS];
  logic [ADDR_W-1:0]   tbl_stop    [REGION_SLOTS];
  logic [FLAGS_W-1:0]  tbl_flags   [REGION_SLOTS];
  logic                tbl_enabled [REGION_SLOTS];
  int unsigned         tbl_count = 0;

  watch_result_t expected_results[$];
  int  mismatches = 0;
  bit  quiet = 0;
  bit  hold_req = 0;
  int  hold_len = 0;

  memory_watch_region_matcher_top #(
    .MAX_REGIONS(REGION_SLOTS)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_access_pc       (in_access_pc),
    .in_access_addr     (in_access_addr),
    .in_access_size     (in_access_size),
    .in_access_write    (in_access_write),
    .in_access_before   (in_access_before),
    .in_access_physical (in_access_physical),
    .in_region_start    (in_region_start),
    .in_region_stop     (in_region_stop),
    .in_region_flags    (in_region_flags),
    .in_region_enabled  (in_region_enabled),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_region_index   (out_region_index),
    .out_hit_pc         (out_hit_pc),
    .out_hit_addr       (out_hit_addr),
    .out_hit_size       (out_hit_size),
    .out_hit_write      (out_hit_write),
    .out_hit_before     (out_hit_before),
    .out_hit_physical   (out_hit_physical),
    .out_last           (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic bit coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit region_matches(int idx, watch_word_t w);
    logic [ADDR_W-1:0]  s;
    logic [ADDR_W-1:0]  t;
    logic [ADDR_W-1:0]  e;
    logic [FLAGS_W-1:0] f;
    bit span, dir, phase, space;
    s = tbl_start[idx];
    t = tbl_stop[idx];
    f = tbl_flags[idx];
    // end of access wraps at 2^64
    e = w.addr + ADDR_W'(w.size);
    span = (w.addr >= s && w.addr < t) || (e > s && e <= t) || (w.addr >= s && e <= t);
    dir = w.wr ? f[FLAG_WRITE] : f[FLAG_READ];
    phase = w.bf ? f[FLAG_BEFORE] : f[FLAG_AFTER];
    space = w.ph ? f[FLAG_PHYSICAL] : f[FLAG_VIRTUAL];
    return tbl_enabled[idx] && span && dir && phase && space;
  endfunction

  function automatic watch_result_t blank_result(mwrm_pkg::result_kind_t kind,
                                                 logic [INDEX_W-1:0] index);
    watch_result_t r;
    r.kind = kind;
    r.index = index;
    r.pc = '0;
    r.addr = '0;
    r.size = '0;
    r.wr = 1'b0;
    r.bf = 1'b0;
    r.ph = 1'b0;
    r.is_last = 1'b1;
    return r;
  endfunction

  function automatic void add_expected(watch_result_t r);
    expected_results = {expected_results, r};
  endfunction

  task automatic predict_results(input watch_word_t w);
    watch_result_t hits[$];
    watch_result_t r;
    if (w.op == mwrm_pkg::OP_ADD) begin
      if (tbl_count == REGION_SLOTS) begin
        add_expected(blank_result(mwrm_pkg::KIND_FULL, '0));
      end else begin
        tbl_start[tbl_count] = w.rstart;
        tbl_stop[tbl_count] = w.rstop;
        tbl_flags[tbl_count] = w.rflags;
        tbl_enabled[tbl_count] = w.ren;
        add_expected(blank_result(mwrm_pkg::KIND_ADDED, INDEX_W'(tbl_count)));
        tbl_count++;
      end
    end else begin
      for (int i = 0; i < tbl_count; i++) begin
        if (region_matches(i, w)) begin
          r.kind = mwrm_pkg::KIND_HIT;
          r.index = INDEX_W'(i);
          r.pc = w.pc;
          r.addr = w.addr;
          r.size = w.size;
          r.wr = w.wr;
          r.bf = w.bf;
          r.ph = w.ph;
          r.is_last = 1'b0;
          hits = {hits, r};
        end
      end
      if (hits.size() > 0) hits[hits.size()-1].is_last = 1'b1;
      foreach (hits[i]) add_expected(hits[i]);
    end
  endtask

  function automatic watch_word_t check_word(logic [ADDR_W-1:0] pc, logic [ADDR_W-1:0] addr,
                                             logic [SIZE_W-1:0] size, logic wr, logic bf,
                                             logic ph);
    watch_word_t w;
    w.op = mwrm_pkg::OP_CHECK;
    w.pc = pc;
    w.addr = addr;
    w.size = size;
    w.wr = wr;
    w.bf = bf;
    w.ph = ph;
    w.rstart = '0;
    w.rstop = '0;
    w.rflags = '0;
    w.ren = 1'b0;
    return w;
  endfunction

  function automatic watch_word_t add_word(logic [ADDR_W-1:0] start, logic [ADDR_W-1:0] stop,
                                           logic [FLAGS_W-1:0] flags, logic en);
    watch_word_t w;
    w = check_word('0, '0, '0, 1'b0, 1'b0, 1'b0);
    w.op = mwrm_pkg::OP_ADD;
    w.rstart = start;
    w.rstop = stop;
    w.rflags = flags;
    w.ren = en;
    return w;
  endfunction

  // near: aim the access at the edge of a stored region
  function automatic watch_word_t random_check(bit near);
    watch_word_t w;
    logic [ADDR_W-1:0] anchor;
    int k;
    w.op = mwrm_pkg::OP_CHECK;
    w.pc = rand64();
    w.wr = coin();
    w.bf = coin();
    w.ph = coin();
    w.rstart = rand64();
    w.rstop = rand64();
    w.rflags = FLAGS_W'($urandom_range(0, 63));
    w.ren = coin();
    if (near && tbl_count > 0) begin
      k = $urandom_range(0, tbl_count - 1);
      anchor = coin() ? tbl_start[k] : tbl_stop[k];
      w.addr = anchor + ADDR_W'($urandom_range(0, 64)) - ADDR_W'(32);
      w.size = ($urandom_range(0, 7) == 0) ? SIZE_W'($urandom_range(0, 4096))
                                           : SIZE_W'($urandom_range(0, 16));
    end else begin
      w.addr = rand64();
      w.size = SIZE_W'($urandom_range(0, 4096));
    end
    return w;
  endfunction

  function automatic watch_word_t random_add();
    watch_word_t w;
    logic [ADDR_W-1:0] base;
    int k;
    w = random_check(1'b0);
    w.op = mwrm_pkg::OP_ADD;
    case ($urandom_range(0, 3))
      0: base = 64'h1000;
      1: base = 64'hFFFF_FFFF_FFFF_F000;
      2: base = (tbl_count > 0) ? tbl_start[$urandom_range(0, tbl_count - 1)] : '0;
      default: base = rand64();
    endcase
    w.rstart = base + ADDR_W'($urandom_range(0, 'h800));
    k = $urandom_range(0, 7);
    if (k == 0) w.rstop = w.rstart;
    else if (k == 1) w.rstop = rand64();
    else w.rstop = w.rstart + ADDR_W'($urandom_range(1, 'h2000));
    w.rflags = coin() ? '1 : FLAGS_W'($urandom_range(0, 63));
    w.ren = ($urandom_range(0, 7) != 0);
    return w;
  endfunction

  // offer one word and hold it until the block takes it
  task automatic send_word(input watch_word_t w);
    in_valid <= 1'b1;
    in_opcode <= w.op;
    in_access_pc <= w.pc;
    in_access_addr <= w.addr;
    in_access_size <= w.size;
    in_access_write <= w.wr;
    in_access_before <= w.bf;
    in_access_physical <= w.ph;
    in_region_start <= w.rstart;
    in_region_stop <= w.rstop;
    in_region_flags <= w.rflags;
    in_region_enabled <= w.ren;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_results(w);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_empty_table();
    send_word(check_word(ALL_ONES, ALL_ONES, 13'd4096, 1'b1, 1'b1, 1'b1));
    sender_gap();
    send_word(check_word('0, '0, '0, 1'b0, 1'b0, 1'b0));
    sender_gap();
  endtask

  task automatic test_directed_regions();
    watch_word_t adds[7];
    adds[0] = add_word(64'h1000, 64'h2000, '1, 1'b1);
    adds[1] = add_word('0, ALL_ONES, '1, 1'b0);
    adds[2] = add_word(64'hFFFF_FFFF_FFFF_F000, ALL_ONES, '1, 1'b1);
    adds[3] = add_word('0, 64'h100, '1, 1'b1);
    adds[4] = add_word(64'h1800, 64'h1900, KINDS_RBV, 1'b1);
    adds[5] = add_word(64'h1800, 64'h1900, KINDS_WAP, 1'b1);
    // stop below start never matches
    adds[6] = add_word(64'h3000, 64'h2000, '1, 1'b1);
    foreach (adds[i]) begin
      send_word(adds[i]);
      sender_gap();
    end
  endtask

  task automatic test_range_edges();
    watch_word_t checks[8];
    checks[0] = check_word('0, 64'h1000, 13'd0, 1'b0, 1'b1, 1'b0);
    // touching the start from below, then one byte into it
    checks[1] = check_word(rand64(), 64'h0FF0, 13'h10, 1'b1, 1'b0, 1'b1);
    checks[2] = check_word(rand64(), 64'h0FF0, 13'h11, 1'b1, 1'b0, 1'b1);
    // touching the stop, then the last byte
    checks[3] = check_word(rand64(), 64'h2000, 13'd4, 1'b0, 1'b0, 1'b0);
    checks[4] = check_word(rand64(), 64'h1FFF, 13'd1, 1'b0, 1'b0, 1'b0);
    // access end wraps past zero into the low region
    checks[5] = check_word(rand64(), 64'hFFFF_FFFF_FFFF_FF00, 13'h200, 1'b1, 1'b1, 1'b1);
    checks[6] = check_word(ALL_ONES, ALL_ONES, 13'd4096, 1'b1, 1'b1, 1'b1);
    checks[7] = check_word(rand64(), '0, 13'd0, 1'b0, 1'b0, 1'b0);
    foreach (checks[i]) begin
      send_word(checks[i]);
      sender_gap();
    end
  endtask

  task automatic test_kind_flags();
    for (int c = 0; c < 8; c++) begin
      send_word(check_word(rand64(), 64'h1850, 13'd8, c[2], c[1], c[0]));
      sender_gap();
    end
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0) send_word(random_add());
      else send_word(random_check($urandom_range(0, 9) != 0));
      sender_gap();
    end
  endtask

  // receiver holds off while hit-heavy words keep coming, so the input backs up
  task automatic test_output_hold();
    hold_len = 150;
    hold_req = 1'b1;
    for (int i = 0; i < 10; i++)
      send_word(check_word(rand64(), 64'h1850, 13'd8, coin(), coin(), coin()));
  endtask

  initial begin : stall_gen
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    watch_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: kind %0d index %0d addr %h last %b",
                   out_result_kind, out_region_index, out_hit_addr, out_last);
      end else begin
        want = expected_results.pop_front();
        if (out_result_kind !== want.kind || out_region_index !== want.index ||
            out_hit_pc !== want.pc || out_hit_addr !== want.addr ||
            out_hit_size !== want.size || out_hit_write !== want.wr ||
            out_hit_before !== want.bf || out_hit_physical !== want.ph ||
            out_last !== want.is_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch (exp/got): kind %0d/%0d index %0d/%0d pc %h/%h ",
                      "addr %h/%h size %0d/%0d wr %b/%b bf %b/%b ph %b/%b last %b/%b"},
                     want.kind, out_result_kind, want.index, out_region_index,
                     want.pc, out_hit_pc, want.addr, out_hit_addr,
                     want.size, out_hit_size, want.wr, out_hit_write,
                     want.bf, out_hit_before, want.ph, out_hit_physical,
                     want.is_last, out_last);
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= 1'b0;
    in_access_pc <= '0;
    in_access_addr <= '0;
    in_access_size <= '0;
    in_access_write <= 1'b0;
    in_access_before <= 1'b0;
    in_access_physical <= 1'b0;
    in_region_start <= '0;
    in_region_stop <= '0;
    in_region_flags <= '0;
    in_region_enabled <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_directed_regions();
    test_range_edges();
    test_kind_flags();
    test_random_traffic(150);
    test_output_hold();
    wait_for_results();
    test_random_traffic(150);
    quiet = 1'b1;
    test_random_traffic(70);

    wait_for_results();
    repeat (50) @(posedge clk);
    mismatches += expected_results.size();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
